// File: hw/rtl/b64c_pkg.sv
// Shared types, constants and character tables for the base64 codec.
`default_nettype none

package b64c_pkg;

  // Mode register codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Special characters of the alphabet.
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  // Default depth of the queue between the front and back parts (power of two, >= 2).
  localparam int QUEUE_DEPTH = 2;

  // One group's worth of results, already packed in delivery order.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte of this group
    logic            last;      // final byte carries the end-of-message mark
  } job_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26)      r = 8'h41 + {2'b00, v};
    else if (v < 6'd52) r = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) r = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) r = CHAR_PLUS;
    else                r = CHAR_SLASH;
    return r;
  endfunction

  // Alphabet character to six-bit value; anything else is zero.
  function automatic logic [5:0] dec_char(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A)      r = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30 + 8'd52;
    else if (c == CHAR_PLUS)           r = 8'd62;
    else if (c == CHAR_SLASH)          r = 8'd63;
    else                               r = 8'd0;
    return r[5:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b64c_front.sv
// Front part: takes input transactions, gathers groups and builds result jobs.
`default_nettype none

module b64c_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic          cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_message,
  output logic               push_valid,
  input  wire logic          push_ready,
  output b64c_pkg::job_t     push_data
);

  logic        mode;
  logic [17:0] hold;
  logic [1:0]  count;
  logic        third_pad;

  logic [17:0] hold_next;
  logic [1:0]  count_next;
  logic        third_pad_next;
  logic        emit;
  logic [1:0]  cnt;
  logic [23:0] v;
  logic [5:0]  val;
  logic        fourth_pad;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_next      = hold;
    count_next     = count;
    third_pad_next = third_pad;
    emit           = 1'b0;
    cnt            = count + 2'd1;
    val            = b64c_pkg::dec_char(data_byte);
    fourth_pad     = (data_byte == b64c_pkg::CHAR_PAD);
    v              = '0;
    push_data      = '0;
    push_data.last = end_of_message;

    if (mode == b64c_pkg::MODE_ENCODE) begin
      case (cnt)
        2'd1:    v = {data_byte, 16'h0000};
        2'd2:    v = {hold[7:0], data_byte, 8'h00};
        default: v = {hold[15:0], data_byte};
      endcase
      emit = (cnt == 2'd3) || end_of_message;
      push_data.bytes[0] = b64c_pkg::enc_char(v[23:18]);
      push_data.bytes[1] = b64c_pkg::enc_char(v[17:12]);
      push_data.bytes[2] = (cnt != 2'd1) ? b64c_pkg::enc_char(v[11:6]) : b64c_pkg::CHAR_PAD;
      push_data.bytes[3] = (cnt == 2'd3) ? b64c_pkg::enc_char(v[5:0]) : b64c_pkg::CHAR_PAD;
      push_data.last_idx = 2'd3;
      if (emit) begin
        hold_next  = '0;
        count_next = '0;
      end else begin
        hold_next  = {2'b00, hold[7:0], data_byte};
        count_next = cnt;
      end
    end else begin
      v = {hold, val};
      emit = (count == 2'd3);
      push_data.bytes[0] = v[23:16];
      push_data.bytes[1] = third_pad ? v[7:0] : v[15:8];
      push_data.bytes[2] = v[7:0];
      push_data.last_idx = {1'b0, ~third_pad} + {1'b0, ~fourth_pad};
      if (emit || end_of_message) begin
        hold_next      = '0;
        count_next     = '0;
        third_pad_next = 1'b0;
      end else begin
        hold_next  = {hold[11:0], val};
        count_next = cnt;
        if (count == 2'd2) begin
          third_pad_next = fourth_pad;
        end
      end
    end
  end

  assign push_valid = in_valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= b64c_pkg::MODE_ENCODE;
      hold      <= '0;
      count     <= '0;
      third_pad <= 1'b0;
    end else if (cfg_write) begin
      mode      <= cfg_data;
      hold      <= '0;
      count     <= '0;
      third_pad <= 1'b0;
    end else if (accept) begin
      hold      <= hold_next;
      count     <= count_next;
      third_pad <= third_pad_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64c_queue.sv
// Small job queue between the front and back parts.
`default_nettype none

module b64c_queue #(
  parameter int DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire b64c_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output b64c_pkg::job_t      pop_data
);

  localparam int AW = $clog2(DEPTH);

  b64c_pkg::job_t entries [DEPTH];
  logic [AW:0]    wr_ptr;
  logic [AW:0]    rd_ptr;
  logic           empty;
  logic           full;

  assign empty      = (wr_ptr == rd_ptr);
  assign full       = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_data   = entries[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      entries[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_valid && push_ready) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_valid && pop_ready) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64c_back.sv
// Back part: holds one job and sends its bytes out one transaction at a time.
`default_nettype none

module b64c_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire b64c_pkg::job_t pop_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                last
);

  b64c_pkg::job_t job;
  logic           has_job;
  logic [1:0]     idx;
  logic           at_end;

  assign at_end    = (idx == job.last_idx);
  assign pop_ready = !has_job || (out_ready && at_end);
  assign out_valid = has_job;
  assign out_byte  = job.bytes[idx];
  assign last      = job.last && at_end;

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      job <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_job <= 1'b0;
      idx     <= '0;
    end else if (pop_ready) begin
      has_job <= pop_valid;
      idx     <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/base64_codec_unit.sv
// Top level of the streaming base64 encoder and decoder.
//
//   channel   direction  signals                                   handshake
//   in        sink       data_byte, end_of_message                 in_valid / in_ready
//   out       source     out_byte, last                            out_valid / out_ready
//   cfg       sink       cfg_data (mode)                           cfg_write, no wait
//
// An input transaction is taken whenever the queue has room. The transaction that
// completes a group pushes a job into the queue, the back part loads it into its job
// register, and its bytes then go out one per cycle while out_ready is high. The output
// serializer sets the sustained rate when encoding: four characters per three bytes.
// Reset (synchronous, active high) selects encode mode and empties all groups and queues.
// The front and back stall independently through a queue of QUEUE_DEPTH jobs.
`default_nettype none

module base64_codec_unit #(
  parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last
);

  // Jobs carry the finished bytes of one group, so the back part only counts them out.
  b64c_pkg::job_t push_data;
  b64c_pkg::job_t pop_data;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  // The front classifies each transaction by mode and stores it in the group register,
  // completes the group and pushes a job, or in decode mode drops a group that the message ends inside.
  b64c_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back holds the current job in a register and walks through its bytes.
  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/b64c_checker.sv
// Port-level assertions for the base64 codec, bound to the top level.
`default_nettype none

module b64c_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  // Nothing is shown right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // With the output side empty, the queue cannot be full.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled while output is idle");

  // No result appears without an input transaction shortly before.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result without a preceding input");

endmodule

bind base64_codec_unit b64c_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last      (last)
);

`default_nettype wire

// File: test/b64_stream_checker.sv
// Scoreboard that predicts and checks the output stream of the base64 codec.
module b64_stream_checker
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last,
  output int         owed_count,
  output int         fail_count
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } coded_byte_t;

  coded_byte_t owed_bytes[$];
  int          owed_now = 0;
  int          fails = 0;

  logic        codec_mode = MODE_ENCODE;
  logic [23:0] gathered = '0;
  int          gathered_count = 0;
  logic        third_was_pad = 1'b0;

  assign owed_count = owed_now;
  assign fail_count = fails;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (v < 8'd26) return 8'd65 + v;
    if (v < 8'd52) return 8'd71 + v;
    if (v < 8'd62) return v - 8'd4;
    return (v == 8'd62) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - 8'd65);
    if (c >= "a" && c <= "z") return 6'(c - 8'd71);
    if (c >= "0" && c <= "9") return 6'(c + 8'd4);
    if (c == CHAR_PLUS) return 6'd62;
    if (c == CHAR_SLASH) return 6'd63;
    return 6'd0;
  endfunction

  function automatic void clear_group();
    gathered       = '0;
    gathered_count = 0;
    third_was_pad  = 1'b0;
  endfunction

  // Works out the bytes that one input transaction releases, in delivery order.
  task automatic absorb_transaction(input logic [7:0] c, input logic eom);
    logic [7:0]  res[4];
    int          n;
    int          cnt;
    logic [23:0] v;
    n = 0;
    if (codec_mode == MODE_ENCODE) begin
      cnt      = gathered_count + 1;
      gathered = {gathered[15:0], c};
      if (cnt < 3 && !eom) begin
        gathered_count = cnt;
        return;
      end
      // A short group is left aligned, and its missing characters become pads.
      v      = gathered << (8 * (3 - cnt));
      res[0] = sextet_to_char(v[23:18]);
      res[1] = sextet_to_char(v[17:12]);
      res[2] = (cnt >= 2) ? sextet_to_char(v[11:6]) : CHAR_PAD;
      res[3] = (cnt >= 3) ? sextet_to_char(v[5:0]) : CHAR_PAD;
      n      = 4;
    end else begin
      if (gathered_count < 3) begin
        if (gathered_count == 2) third_was_pad = (c == CHAR_PAD);
        gathered       = {gathered[17:0], char_to_sextet(c)};
        gathered_count = gathered_count + 1;
        // A message that ends inside a group produces nothing at all.
        if (eom) clear_group();
        return;
      end
      v      = {gathered[17:0], char_to_sextet(c)};
      res[0] = v[23:16];
      n      = 1;
      if (!third_was_pad) begin
        res[n] = v[15:8];
        n      = n + 1;
      end
      if (c != CHAR_PAD) begin
        res[n] = v[7:0];
        n      = n + 1;
      end
    end
    clear_group();
    for (int k = 0; k < n; k++) owed_bytes.push_back('{res[k], eom && (k == n - 1)});
  endtask

  always @(posedge clk) begin
    coded_byte_t exp_byte;
    if (rst) begin
      codec_mode = MODE_ENCODE;
      clear_group();
      owed_bytes.delete();
    end else begin
      if (cfg_write) begin
        codec_mode = cfg_data;
        clear_group();
      end
      if (in_valid && in_ready) absorb_transaction(data_byte, end_of_message);
      if (out_valid && out_ready) begin
        if (owed_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h, last %0d", out_byte, last);
          fails++;
        end else begin
          exp_byte = owed_bytes.pop_front();
          if (out_byte !== exp_byte.ch) begin
            $error("out_byte mismatch: expected %02h, actual %02h", exp_byte.ch, out_byte);
            fails++;
          end
          if (last !== exp_byte.last) begin
            $error("last mismatch: expected %0d, actual %0d", exp_byte.last, last);
            fails++;
          end
        end
      end
    end
    owed_now = owed_bytes.size();
  end

endmodule

// File: test/tb_top.sv
// Stimulus, flow control and verdict for the base64 codec regression.
module tb_top;
  import b64c_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last;

  int owed_count;
  int fail_count;
  int items_sent = 0;

  // Flow-control switches shared by the sender and the receiver.
  // calm_tail turns off all idling for the final stretch of the run,
  // sender_steady turns off sender gaps for whole phases, and
  // backlog_request asks the receiver for one long hold-off.
  bit calm_tail = 1'b0;
  bit sender_steady = 1'b0;
  bit backlog_request = 1'b0;
  bit backlog_done = 1'b0;

  always #1 clk = ~clk;

  base64_codec_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last)
  );

  // The checker sits beside the block, watches both channels and the
  // mode register, and hands back its failure count.
  b64_stream_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last),
    .owed_count     (owed_count),
    .fail_count     (fail_count)
  );

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: out_ready changes in random bursts, mostly high. Once during
  // the run it holds off long enough that the block fills up and has to
  // stall its input.
  initial begin : receiver
    int span;
    forever begin
      if (backlog_request && !backlog_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        backlog_done = 1'b1;
      end else if (calm_tail) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        span = $urandom_range(1, 16);
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offers one input transaction, steps the clock and then waits while in_ready
  // is low. Before the offer the sender may pause for a random burst. Valid is
  // not lowered between back-to-back transactions, only the payload changes.
  task automatic send_item(input logic [7:0] b, input logic eom);
    if (!sender_steady && !calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Sends a string one character per transaction; with close set, the final
  // character ends the message.
  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], close && (i == s.len() - 1));
  endtask

  // Lets the block run dry. The clock steps first so the checker has seen the
  // last accepted transaction, then every owed byte must arrive, then a further
  // wait covers a group that ended without producing anything.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Mode writes happen only with the block idle. Any write, even to the
  // current mode, throws away a partly gathered group.
  task automatic set_mode(input logic m);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] any_b64_char();
    return enc_char(6'($urandom_range(0, 63)));
  endfunction

  // Encode messages of 1 to 10 bytes cover all three group remainders.
  task automatic random_encode_message();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) send_item(8'($urandom), i == len - 1);
  endtask

  // Mostly well formed decode messages with a random pad pattern in the final
  // group, including the odd case of a pad in third place only. About one in
  // five is noise: arbitrary bytes and lengths, which gives stray characters,
  // misplaced pads and messages that stop inside a group.
  task automatic random_decode_message();
    int         groups;
    int         pads;
    logic [7:0] third;
    logic [7:0] fourth;
    if ($urandom_range(0, 4) == 0) begin
      groups = $urandom_range(1, 9);
      for (int i = 0; i < groups; i++) send_item(8'($urandom), i == groups - 1);
      return;
    end
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups - 1; g++) repeat (4) send_item(any_b64_char(), 1'b0);
    pads   = $urandom_range(0, 3);
    third  = (pads >= 2) ? CHAR_PAD : any_b64_char();
    fourth = (pads == 1 || pads == 2) ? CHAR_PAD : any_b64_char();
    send_item(any_b64_char(), 1'b0);
    send_item(any_b64_char(), 1'b0);
    send_item(third, 1'b0);
    send_item(fourth, 1'b1);
  endtask

  initial begin : stimulus
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed encode: one and two byte tails, a full group whose characters
    // reach '+' and '/', a group ending without the end mark, and a partial
    // group that the next mode write must discard.
    set_mode(MODE_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h41, 1'b0);

    // Directed decode: alphabet boundaries, characters outside the alphabet,
    // both pads, a lone pad in third place, a message cut inside a group and
    // a partial group dropped by rewriting the same mode.
    set_mode(MODE_DECODE);
    send_text("AZaz09+/", 1'b0);
    send_item(8'h00, 1'b0);
    send_item("!", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_PAD, 1'b1);
    send_text("TQ==", 1'b1);
    send_text("xx=y", 1'b1);
    send_text("QU", 1'b1);
    send_text("Q", 1'b0);
    set_mode(MODE_DECODE);
    send_text("TWFu", 1'b1);

    // Random phases alternate the mode. Every third phase the sender runs
    // without gaps, and phase two starts with the long receiver hold-off.
    phase = 0;
    while (items_sent < 470) begin
      set_mode((phase % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
      sender_steady = (phase % 3 == 2);
      if (phase == 2) backlog_request = 1'b1;
      repeat ($urandom_range(4, 10)) begin
        calm_tail = (items_sent >= 440);
        if (phase % 2 == 0) random_encode_message();
        else random_decode_message();
      end
      phase++;
    end

    calm_tail = 1'b1;
    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: base64_codec_unit.f
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_queue.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_codec_unit.sv
hw/rtl/b64c_checker.sv
test/b64_stream_checker.sv
test/tb_top.sv
